### design/brl_pkg.sv
// Shared types, widths and constants of the burst rate limiter.
package brl_pkg;

  localparam int MEAN_FRAC_BITS_DEF = 8;

  localparam int ACT_W     = 2;
  localparam int LEN_W     = 16;
  localparam int TIME_W    = 64;
  localparam int MEAN_W    = 24;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 16;
  localparam int LIMIT_W   = 16;
  localparam int BPS_W     = 40;
  localparam int FREQ_W    = 32;
  localparam int CFG_W     = 40;
  localparam int CFG_IDX_W = 2;

  localparam int BYTE_SHIFT = 3;
  localparam int BITS_W     = MEAN_W + LIMIT_W + BYTE_SHIFT;
  localparam int MUL_SPLIT  = 32;
  localparam int DIV_NUM_W  = FREQ_W + BITS_W;
  localparam int DIV_DEN_W  = BPS_W;

  localparam int MEAN_INIT_INT = 98;
  localparam int MEAN_WEIGHT   = 10;
  localparam int MEAN_DIVISOR  = 11;

  // Multiplying by MEAN_RECIP and shifting right by MEAN_RECIP_SHIFT divides by MEAN_DIVISOR
  // exactly for every dividend below 2**MEAN_RECIP_IN_W.
  localparam int MEAN_RECIP_IN_W  = MEAN_W + 4;
  localparam int MEAN_RECIP_W     = 29;
  localparam int MEAN_RECIP_SHIFT = 32;
  localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP = 29'd390451573;

  localparam logic [LIMIT_W-1:0] BURST_LIMIT_RESET = LIMIT_W'(32);
  localparam logic [BPS_W-1:0]   BPS_RESET         = BPS_W'(64'd10000000000);
  localparam logic [BPS_W-1:0]   BPS_DEFAULT       = BPS_W'(64'd10000000000);
  localparam logic [FREQ_W-1:0]  FREQ_RESET        = FREQ_W'(100000000);

  localparam logic [ACT_W-1:0] ACT_SAMPLE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RECOMPUTE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_GO        = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_BPS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_FREQ  = 2'd2;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_RECOMPUTE,
    OP_GO
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [LEN_W-1:0]  len;
    logic              last;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] burst_limit;
    logic [BPS_W-1:0]   bps;
    logic [FREQ_W-1:0]  freq;
  } cfg_t;

endpackage

### design/brl_front.sv
// Front end: accepts input transfers, classifies the action and queues the work.
module brl_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  logic [brl_pkg::ACT_W-1:0]    in_action,
  input  logic [brl_pkg::LEN_W-1:0]    in_packet_length,
  input  logic                         in_last_in_burst,
  input  logic [brl_pkg::TIME_W-1:0]   in_now,
  output logic                         in_full,
  output logic                         item_valid,
  output brl_pkg::item_t               item,
  input  logic                         item_ready
);
  import brl_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int QCNT_W = $clog2(DEPTH + 1);

  item_t              mem_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r;
  logic [PTR_W-1:0]   rptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic [QCNT_W-1:0]  cnt_nxt;
  logic               keep;
  op_t                op;
  logic               wr;
  logic               rd;

  always_comb begin
    keep = 1'b1;
    op   = OP_SAMPLE;
    unique case (in_action)
      ACT_SAMPLE:    op = OP_SAMPLE;
      ACT_RECOMPUTE: op = OP_RECOMPUTE;
      ACT_GO:        op = OP_GO;
      default:       keep = 1'b0;
    endcase
  end

  assign in_full    = (cnt_r == QCNT_W'(DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = mem_r[rptr_r];
  assign wr         = in_push && !in_full && keep;
  assign rd         = item_valid && item_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (rd) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wptr_r] <= '{op: op, len: in_packet_length, last: in_last_in_burst,
                         now: in_now};
    end
  end

endmodule

### design/brl_div.sv
// Restoring divider that retires one quotient bit per cycle.
module brl_div #(
  parameter int NUM_W = brl_pkg::DIV_NUM_W,
  parameter int DEN_W = brl_pkg::DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  import brl_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [NUM_W-1:0]  nq_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, nq_r[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};
  assign done  = done_r;
  assign quo   = nq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      nq_r  <= num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nq_r  <= {nq_r[NUM_W-2:0], ge};
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (step_r == STEP_W'(1)) && !start |=> done_r && !busy_r)
    else $error("divider did not finish after its last step");

endmodule

### design/brl_back.sv
// Back end: burst accumulation, mean and interval update, go decisions.
module brl_back #(
  parameter int MEAN_FRAC_BITS = brl_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  input  brl_pkg::item_t item,
  output logic           item_ready,
  input  brl_pkg::cfg_t  cfg,
  output logic           out_empty,
  input  logic           out_pop,
  output logic           out_go
);
  import brl_pkg::*;

  localparam logic [MEAN_W-1:0] MEAN_RESET =
    MEAN_W'(MEAN_INIT_INT * (2 ** MEAN_FRAC_BITS));
  localparam int HI_W = BITS_W - MUL_SPLIT;
  localparam logic [DIV_NUM_W-1:0] MEAN_SAT = DIV_NUM_W'(MEAN_DIVISOR) << MEAN_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_MEAN,
    ST_BITS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_NUM,
    ST_TICKS
  } state_t;

  state_t                      state_r;
  logic [MEAN_W-1:0]           mean_r;
  logic [TIME_W-1:0]           next_r;
  logic [TIME_W-1:0]           granted_r;
  logic [SUM_W-1:0]            sum_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [BITS_W-1:0]           bits_r;
  logic [FREQ_W+MUL_SPLIT-1:0] plo_r;
  logic [FREQ_W+HI_W-1:0]      phi_r;
  logic                        out_valid_r;
  logic                        out_go_r;
  logic                        div_start_r;
  logic [DIV_NUM_W-1:0]        div_num_r;
  logic [DIV_DEN_W-1:0]        div_den_r;
  logic [DIV_NUM_W-1:0]        blend_r;

  logic                        div_done;
  logic [DIV_NUM_W-1:0]        div_quo;
  logic                        slot_free;
  logic [SUM_W:0]              sum_ext;
  logic [SUM_W-1:0]            sum_nxt;
  logic [CNT_W-1:0]            cnt_nxt;
  logic [MEAN_W+LIMIT_W-1:0]   mean_prod;
  logic [BITS_W-1:0]           bits_nxt;
  logic [DIV_NUM_W-1:0]        mean_num;
  logic [TIME_W:0]             next_sum;
  logic [DIV_DEN_W-1:0]        bps_eff;
  logic [MEAN_RECIP_IN_W+MEAN_RECIP_W-1:0] recip_prod;

  brl_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign slot_free  = !out_valid_r || out_pop;
  assign item_ready = (state_r == ST_IDLE) && ((item.op != OP_GO) || slot_free);
  assign out_empty  = !out_valid_r;
  assign out_go     = out_go_r;

  always_comb begin
    sum_ext    = {1'b0, sum_r} + (SUM_W + 1)'(item.len);
    sum_nxt    = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    cnt_nxt    = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
    mean_prod  = mean_r * cfg.burst_limit;
    bits_nxt   = (BITS_W'(mean_prod) << BYTE_SHIFT) >> MEAN_FRAC_BITS;
    mean_num   = DIV_NUM_W'(mean_r) * DIV_NUM_W'(MEAN_WEIGHT) + div_quo;
    recip_prod = blend_r[MEAN_RECIP_IN_W-1:0] * MEAN_RECIP;
    next_sum   = {1'b0, granted_r} + {1'b0, div_quo[TIME_W-1:0]};
    bps_eff    = (cfg.bps == '0) ? BPS_DEFAULT : cfg.bps;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mean_r      <= MEAN_RESET;
      next_r      <= '0;
      granted_r   <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (item_valid && item_ready) begin
            unique case (item.op)
              OP_SAMPLE: begin
                if (item.last) begin
                  sum_r       <= '0;
                  cnt_r       <= '0;
                  div_num_r   <= DIV_NUM_W'(sum_nxt) << MEAN_FRAC_BITS;
                  div_den_r   <= DIV_DEN_W'(cnt_nxt);
                  div_start_r <= 1'b1;
                  state_r     <= ST_AVG;
                end else begin
                  sum_r <= sum_nxt;
                  cnt_r <= cnt_nxt;
                end
              end
              OP_RECOMPUTE: begin
                state_r <= ST_BITS;
              end
              OP_GO: begin
                out_valid_r <= 1'b1;
                out_go_r    <= (item.now >= next_r);
                if (item.now >= next_r) begin
                  granted_r <= item.now;
                end
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_AVG: begin
          if (div_done) begin
            blend_r <= mean_num;
            state_r <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          mean_r  <= (blend_r >= MEAN_SAT) ? '1 : recip_prod[MEAN_RECIP_SHIFT +: MEAN_W];
          state_r <= ST_BITS;
        end
        ST_BITS: begin
          bits_r  <= bits_nxt;
          state_r <= ST_MUL_LO;
        end
        ST_MUL_LO: begin
          plo_r   <= cfg.freq * bits_r[MUL_SPLIT-1:0];
          state_r <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          phi_r   <= cfg.freq * bits_r[BITS_W-1:MUL_SPLIT];
          state_r <= ST_NUM;
        end
        ST_NUM: begin
          div_num_r   <= DIV_NUM_W'(plo_r) + (DIV_NUM_W'(phi_r) << MUL_SPLIT);
          div_den_r   <= bps_eff;
          div_start_r <= 1'b1;
          state_r     <= ST_TICKS;
        end
        ST_TICKS: begin
          if (div_done) begin
            if ((div_quo[DIV_NUM_W-1:TIME_W] != '0) || next_sum[TIME_W]) begin
              next_r <= '1;
            end else begin
              next_r <= next_sum[TIME_W-1:0];
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !item_ready)
    else $error("work taken while an update is in progress");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_AVG) || (state_r == ST_TICKS))
    else $error("divider result arrived in an unexpected state");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pop |=> out_valid_r && $stable(out_go_r))
    else $error("waiting result lost or changed");

endmodule

### design/burst_rate_limiter.sv
// Top level of the burst rate limiter: configuration registers and front and back ends.
// Items enter through a two-entry queue; a length sample without the end-of-burst mark and a
// go query are each handled in the idle state of the back end, and a go query waits while
// its result slot is still occupied. A sample that ends a burst, and a recompute item, run
// through one shared bit-serial divider of 75 steps, and the mean update divides by eleven
// with a reciprocal multiply: a burst end holds the back end for two divisions plus setup,
// mean and multiply steps, a recompute for one division and its setup and multiply steps.
// Queued items keep their order, so a go query always sees the interval left by earlier items.
module burst_rate_limiter #(
  parameter int MEAN_FRAC_BITS = brl_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic [brl_pkg::ACT_W-1:0]      in_action,
  input  logic [brl_pkg::LEN_W-1:0]      in_packet_length,
  input  logic                           in_last_in_burst,
  input  logic [brl_pkg::TIME_W-1:0]     in_now,
  output logic                           in_full,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_go,
  input  logic                           cfg_we,
  input  logic [brl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brl_pkg::CFG_W-1:0]      cfg_data
);
  import brl_pkg::*;

  cfg_t  cfg_r;
  logic  item_valid;
  logic  item_ready;
  item_t item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.burst_limit <= BURST_LIMIT_RESET;
      cfg_r.bps         <= BPS_RESET;
      cfg_r.freq        <= FREQ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BURST_LIMIT: cfg_r.burst_limit <= cfg_data[LIMIT_W-1:0];
        CFG_RATE_BPS:    cfg_r.bps         <= cfg_data[BPS_W-1:0];
        CFG_TIMER_FREQ:  cfg_r.freq        <= cfg_data[FREQ_W-1:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  brl_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_action        (in_action),
    .in_packet_length (in_packet_length),
    .in_last_in_burst (in_last_in_burst),
    .in_now           (in_now),
    .in_full          (in_full),
    .item_valid       (item_valid),
    .item             (item),
    .item_ready       (item_ready)
  );

  brl_back #(
    .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .cfg        (cfg_r),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_go     (out_go)
  );

endmodule
